// ===== rtl/lirl_pkg.sv =====
// ----------------------------------------------------------------------------
// lirl_pkg
// shared types, control-store layout and microprogram for the longest
// increasing run length block
// ----------------------------------------------------------------------------
package lirl_pkg;

  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 11;

  // sequencer step addresses
  typedef enum logic [2:0] {
    STEP_IDLE    = 3'd0,
    STEP_PROBE   = 3'd1,
    STEP_COMPARE = 3'd2,
    STEP_UPDATE  = 3'd3,
    STEP_EMIT    = 3'd4
  } step_t;

  // datapath operation of one control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_PROBE,
    OP_NARROW,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  // jump condition of one control word
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SEARCH_DONE,
    COND_NOT_LAST,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;   // taken when cond holds
    step_t nxt;   // taken otherwise
  } ctrl_word_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic search_done;
    logic last;
    logic out_busy;
  } flags_t;

  // control store
  function automatic ctrl_word_t ucode_rom(step_t s);
    ctrl_word_t w;
    case (s)
      STEP_IDLE:    w = '{OP_LOAD,   COND_NO_INPUT,    STEP_IDLE,   STEP_PROBE};
      STEP_PROBE:   w = '{OP_PROBE,  COND_SEARCH_DONE, STEP_UPDATE, STEP_COMPARE};
      STEP_COMPARE: w = '{OP_NARROW, COND_ALWAYS,      STEP_PROBE,  STEP_PROBE};
      STEP_UPDATE:  w = '{OP_UPDATE, COND_NOT_LAST,    STEP_IDLE,   STEP_EMIT};
      STEP_EMIT:    w = '{OP_EMIT,   COND_OUT_BUSY,    STEP_EMIT,   STEP_IDLE};
      default:      w = '{OP_NOP,    COND_ALWAYS,      STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/lirl_ram.sv =====
// ----------------------------------------------------------------------------
// lirl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lirl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lirl_useq.sv =====
// ----------------------------------------------------------------------------
// lirl_useq
// microcoded sequencer: step counter, control store and conditional jumps
// ----------------------------------------------------------------------------
module lirl_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  lirl_pkg::flags_t flags,
  output lirl_pkg::op_t    op
);

  lirl_pkg::step_t      step_r;
  lirl_pkg::step_t      step_nxt;
  lirl_pkg::ctrl_word_t cw;
  logic                 take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lirl_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    cw = lirl_pkg::ucode_rom(step_r);
    case (cw.cond)
      lirl_pkg::COND_ALWAYS:      take = 1'b1;
      lirl_pkg::COND_NO_INPUT:    take = !flags.in_valid;
      lirl_pkg::COND_SEARCH_DONE: take = flags.search_done;
      lirl_pkg::COND_NOT_LAST:    take = !flags.last;
      lirl_pkg::COND_OUT_BUSY:    take = flags.out_busy;
      default:                    take = 1'b1;
    endcase
    step_nxt = take ? cw.tgt : cw.nxt;
    op       = cw.op;
  end

endmodule

// ===== rtl/longest_increasing_run_length_top.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_run_length_top
// strict longest increasing subsequence length by patience sorting, run by a
// microcoded sequencer over a tail-value ram
// ----------------------------------------------------------------------------
// steps: idle loads an item, then probe and compare alternate once per binary
//   search probe (at most ceil(log2(count+1)) probes, 11 at depth 1024), then
//   update, plus emit on a last item; compare waits on the registered ram read port
// throughput: one item at a time, next item taken in the idle step
// reset: synchronous active low, clears count, overflow flag, result valid
//   and step counter; tail ram is not cleared, entries above the count unread
module longest_increasing_run_length_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [lirl_pkg::VALUE_W-1:0] in_value,
  input  logic                           in_last,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lirl_pkg::LENGTH_W-1:0]  out_length,
  output logic                           out_overflow
);

  // count holds 0..TABLE_DEPTH, ram address 0..TABLE_DEPTH-1
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  lirl_pkg::op_t    op;
  lirl_pkg::flags_t flags;

  // search and table state
  logic [lirl_pkg::VALUE_W-1:0] key_r;   // sign flipped so unsigned order works
  logic                         last_r;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [CW-1:0]                mid_r;
  logic [CW-1:0]                mid;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;

  // result register, parts the sequencer from the consumer
  logic                         out_valid_r, out_valid_nxt;
  logic [lirl_pkg::LENGTH_W-1:0] out_length_r;
  logic                         out_overflow_r;
  logic                         out_busy;
  logic [31:0]                  count_ext;

  // ram ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [lirl_pkg::VALUE_W-1:0] ram_rdata;

  lirl_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  lirl_ram #(
    .WIDTH (lirl_pkg::VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .raddr (mid[AW-1:0]),
    .rdata (ram_rdata)
  );

  // midpoint of the open search window, below the count while the window is open
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // a held result blocks the emit step until its transfer completes
  assign out_busy  = out_valid_r && out_stall;
  assign count_ext = 32'(count_r);

  assign flags.in_valid    = in_valid;
  assign flags.search_done = (lo_r >= hi_r);
  assign flags.last        = last_r;
  assign flags.out_busy    = out_busy;

  // input transfer only in the idle step
  assign in_stall = (op != lirl_pkg::OP_LOAD);

  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = lo_r[AW-1:0];
    out_valid_nxt = out_valid_r && out_stall;
    case (op)
      lirl_pkg::OP_LOAD: begin
        // new search window covers every entry in use
        lo_nxt = '0;
        hi_nxt = count_r;
      end
      lirl_pkg::OP_NARROW: begin
        if (ram_rdata < key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      lirl_pkg::OP_UPDATE: begin
        if (lo_r < count_r) begin
          // replace first entry not less than the key
          ram_we = 1'b1;
        end else if (count_r < DEPTH_C) begin
          // append at the end of the table
          ram_we    = 1'b1;
          ram_waddr = count_r[AW-1:0];
          count_nxt = count_r + CW'(1);
        end else begin
          // table full, append dropped
          ovf_nxt = 1'b1;
        end
      end
      lirl_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (op == lirl_pkg::OP_LOAD && in_valid) begin
      key_r  <= {~in_value[lirl_pkg::VALUE_W-1], in_value[lirl_pkg::VALUE_W-2:0]};
      last_r <= in_last;
    end
    if (op == lirl_pkg::OP_PROBE) begin
      mid_r <= mid;
    end
    if (op == lirl_pkg::OP_EMIT && !out_busy) begin
      out_length_r   <= count_ext[lirl_pkg::LENGTH_W-1:0];
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_length   = out_length_r;
  assign out_overflow = out_overflow_r;

endmodule

// ===== sim/tb_longest_increasing_run_length_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_longest_increasing_run_length_top
// self-checking bench for the longest increasing run length block: sequences
// of signed values go in, a tracker rebuilds the tail table of each sequence
// and every length and overflow flag that comes out is compared against it
// ----------------------------------------------------------------------------
module tb_longest_increasing_run_length_top;

  localparam int TABLE_DEPTH   = 1024;
  localparam int IDLE_PCT      = 20;      // chance per cycle of a gap or a stall
  localparam int RANDOM_VALUES = 660;     // short random sequences stop here
  localparam int CYCLE_LIMIT   = 600000;  // watchdog limit on the whole run
  localparam int DRAIN_CYCLES  = 40;      // wait after the last result

  // one length report of a finished sequence
  typedef struct packed {
    logic [lirl_pkg::LENGTH_W-1:0] length;
    logic                          overflow;
  } run_result_t;

  // shapes of random sequences
  typedef enum logic [2:0] {
    PAT_WIDE,       // any 32-bit value
    PAT_NARROW,     // -8..8, lots of repeats
    PAT_RAMP_UP,    // mostly rising, some flat and falling steps
    PAT_RAMP_DOWN,  // mostly falling
    PAT_EDGES       // near the most negative and most positive values and zero
  } pattern_t;

  // tracks the smallest tail per run length and owes one result per sequence
  class run_length_scoreboard;
    logic signed [lirl_pkg::VALUE_W-1:0] tails [TABLE_DEPTH];
    int unsigned                         used;
    bit                                  dropped;
    run_result_t                         expected_lengths [$];
    int unsigned                         failures;

    function new();
      used     = 0;
      dropped  = 1'b0;
      failures = 0;
    endfunction

    function int unsigned results_owed();
      return expected_lengths.size();
    endfunction

    // one accepted value: place it in the tail table
    function void take_value(logic signed [lirl_pkg::VALUE_W-1:0] value, logic last);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      run_result_t done;
      lo = 0;
      hi = used;
      // first tail that is not less than the value
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tails[mid] < value) lo = mid + 1;
        else hi = mid;
      end
      if (lo < used) begin
        tails[lo] = value;
      end else if (used < TABLE_DEPTH) begin
        tails[used] = value;
        used++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        done.length   = used[lirl_pkg::LENGTH_W-1:0];
        done.overflow = dropped;
        expected_lengths.insert(expected_lengths.size(), done);
        used    = 0;
        dropped = 1'b0;
      end
    endfunction

    // one accepted result against the oldest owed one
    function void check_length(logic [lirl_pkg::LENGTH_W-1:0] length, logic overflow);
      run_result_t want;
      if (expected_lengths.size() == 0) begin
        $error("unexpected result: length %0d overflow %0b", length, overflow);
        failures++;
        return;
      end
      want = expected_lengths.pop_front();
      if (length !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, length);
        failures++;
      end
      if (overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
        failures++;
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [lirl_pkg::VALUE_W-1:0]  in_value = '0;
  logic                                 in_last = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [lirl_pkg::LENGTH_W-1:0]        out_length;
  logic                                 out_overflow;

  bit                                   steady = 1'b0;   // no gaps and no stalls while set
  int unsigned                          values_sent = 0;
  int unsigned                          cycle_count = 0;

  run_length_scoreboard run_sb = new();

  longest_increasing_run_length_top #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_length   (out_length),
    .out_overflow (out_overflow)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check each transfer, then pick the stall for the next cycle
  // (out_stall is read here before this edge's update lands)
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      run_sb.check_length(out_length, out_overflow);
    end
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // offer one value, with random gaps ahead of it, and hold it until taken
  task automatic send_item(input logic signed [lirl_pkg::VALUE_W-1:0] value,
                           input logic last);
    while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= last;
    // the edge at which stall was low is the transfer
    do @(posedge clk); while (in_stall);
    run_sb.take_value(value, last);
    values_sent++;
  endtask

  // drop valid and hold off until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (run_sb.results_owed() != 0);
  endtask

  // one sequence of the given shape, last marker on its final value
  task automatic send_sequence(input pattern_t pattern, input int len);
    logic signed [lirl_pkg::VALUE_W-1:0] cur;
    logic signed [lirl_pkg::VALUE_W-1:0] v;
    cur = $urandom;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        PAT_WIDE: begin
          v = $urandom;
        end
        PAT_NARROW: begin
          v = $urandom_range(16);
          v = v - 8;
        end
        PAT_RAMP_UP: begin
          cur = cur + $urandom_range(4) - 1;
          v = cur;
        end
        PAT_RAMP_DOWN: begin
          cur = cur - $urandom_range(4) + 1;
          v = cur;
        end
        default: begin
          case ($urandom_range(2))
            0:       v = 32'h8000_0000 + $urandom_range(3);
            1:       v = 32'h7fff_ffff - $urandom_range(3);
            default: v = $urandom_range(2) - 1;
          endcase
        end
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  // fill the whole table with a strictly rising run, push a few more rising
  // values past the end so they get dropped, then close on a random value
  task automatic send_overflow_run();
    logic signed [lirl_pkg::VALUE_W-1:0] v;
    int extra;
    v = 32'h8000_0000 + $urandom_range(1000);
    extra = $urandom_range(6, 2);
    for (int i = 0; i < TABLE_DEPTH + extra; i++) begin
      send_item(v, 1'b0);
      v = v + $urandom_range(2000000, 1);
    end
    send_item($urandom, 1'b1);
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int       n_seq;
    int       len;
    pattern_t pattern;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single-value sequences, at zero and both extremes
    send_item(32'sh0000_0000, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
    // extremes in both orders
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b1);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
    // repeats never lengthen the run
    send_item(32'sh0000_0005, 1'b0);
    send_item(32'sh0000_0005, 1'b0);
    send_item(32'sh0000_0005, 1'b1);
    // mixed replace and append
    send_item(32'sh0000_0003, 1'b0);
    send_item(32'sh0000_0001, 1'b0);
    send_item(32'sh0000_0004, 1'b0);
    send_item(32'sh0000_0001, 1'b0);
    send_item(32'sh0000_0005, 1'b0);
    send_item(32'sh0000_0009, 1'b0);
    send_item(32'sh0000_0002, 1'b0);
    send_item(32'sh0000_0006, 1'b1);
    // comparisons across the sign boundary
    send_item(32'shffff_ffff, 1'b0);
    send_item(32'sh0000_0000, 1'b1);
    send_item(32'sh0000_0000, 1'b0);
    send_item(32'shffff_ffff, 1'b1);
    wait_drained();

    // random short sequences, with a middle stretch run flat out
    n_seq = 0;
    while (values_sent < RANDOM_VALUES) begin
      steady = (n_seq >= 30) && (n_seq < 60);
      pattern = pattern_t'($urandom_range(PAT_EDGES));
      if ($urandom_range(9) == 0) len = $urandom_range(64, 13);
      else len = $urandom_range(12, 1);
      send_sequence(pattern, len);
      // now and then let the block run dry before the next sequence
      if ($urandom_range(9) == 0) wait_drained();
      n_seq++;
    end
    steady = 1'b0;
    wait_drained();

    // full table and dropped appends
    send_overflow_run();

    // a few short ones after the long run, to see the count and flag cleared
    for (int i = 0; i < 6; i++) begin
      send_sequence(pattern_t'($urandom_range(PAT_EDGES)), $urandom_range(8, 1));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (run_sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== longest_increasing_run_length_top.f =====
rtl/lirl_pkg.sv
rtl/lirl_ram.sv
rtl/lirl_useq.sv
rtl/longest_increasing_run_length_top.sv
sim/tb_longest_increasing_run_length_top.sv
